/* rtl/core/fpa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point ALU.
// This package depends on nothing else. The front, queue and back modules use it.
package fpa_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int WORD_WIDTH = 32;
   // width of the rounded division numerator 2*(|a|<<F) + |b|
   localparam int DIV_BITS   = WORD_WIDTH + FRAC_BITS + 1;
   // partial remainder stays below the divisor 2*|b|
   localparam int REM_BITS   = WORD_WIDTH + 1;
   localparam int PROD_BITS  = 2 * WORD_WIDTH;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_LT  = 4'd4,
      OP_GT  = 4'd5,
      OP_LE  = 4'd6,
      OP_GE  = 4'd7,
      OP_EQ  = 4'd8,
      OP_NE  = 4'd9,
      OP_MIN = 4'd10,
      OP_MAX = 4'd11,
      OP_INC = 4'd12,
      OP_DEC = 4'd13,
      OP_INT = 4'd14
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE,
      KIND_MUL,
      KIND_DIV
   } kind_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [WORD_WIDTH-1:0]  a;
      logic signed [WORD_WIDTH-1:0]  b;
      logic [WORD_WIDTH-1:0]         mag_a;
      logic [WORD_WIDTH-1:0]         mag_b;
      logic                          neg;
      logic [WORD_WIDTH-1:0]         value;
      logic                          cmp;
      logic                          dz;
   } entry_type;

   typedef struct packed {
      kind_type                kind;
      logic [WORD_WIDTH-1:0]   value;
      logic                    cmp;
      logic                    ovf;
      logic                    dz;
      logic                    neg;
   } meta_type;

endpackage

/* rtl/core/fpa_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, decodes the opcode and works out the simple ops.
// Depends on fpa_pkg. It feeds fpa_queue.
module fpa_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_opcode,
   input  logic signed [31:0]    req_operand_a,
   input  logic signed [31:0]    req_operand_b,
   input  logic                  q_full,
   output logic                  push_valid,
   output fpa_pkg::entry_type    push_entry
);

   logic signed [fpa_pkg::WORD_WIDTH-1:0] a;
   logic signed [fpa_pkg::WORD_WIDTH-1:0] b;
   fpa_pkg::opcode_type                   op;

   assign req_stall  = q_full;
   assign push_valid = req_valid;

   always_comb begin
      a  = req_operand_a[fpa_pkg::WORD_WIDTH-1:0];
      b  = req_operand_b[fpa_pkg::WORD_WIDTH-1:0];
      op = fpa_pkg::opcode_type'(req_opcode);
      push_entry       = '0;
      push_entry.kind  = fpa_pkg::KIND_SIMPLE;
      push_entry.a     = a;
      push_entry.b     = b;
      push_entry.mag_a = a[fpa_pkg::WORD_WIDTH-1] ? -a : a;
      push_entry.mag_b = b[fpa_pkg::WORD_WIDTH-1] ? -b : b;
      push_entry.neg   = a[fpa_pkg::WORD_WIDTH-1] ^ b[fpa_pkg::WORD_WIDTH-1];
      case (op)
         fpa_pkg::OP_ADD: push_entry.value = a + b;
         fpa_pkg::OP_SUB: push_entry.value = a - b;
         fpa_pkg::OP_MUL: push_entry.kind  = fpa_pkg::KIND_MUL;
         fpa_pkg::OP_DIV: begin
            push_entry.kind = fpa_pkg::KIND_DIV;
            push_entry.dz   = (b == '0);
         end
         fpa_pkg::OP_LT:  push_entry.cmp   = (a < b);
         fpa_pkg::OP_GT:  push_entry.cmp   = (a > b);
         fpa_pkg::OP_LE:  push_entry.cmp   = (a <= b);
         fpa_pkg::OP_GE:  push_entry.cmp   = (a >= b);
         fpa_pkg::OP_EQ:  push_entry.cmp   = (a == b);
         fpa_pkg::OP_NE:  push_entry.cmp   = (a != b);
         fpa_pkg::OP_MIN: push_entry.value = (a < b) ? a : b;
         fpa_pkg::OP_MAX: push_entry.value = (a > b) ? a : b;
         fpa_pkg::OP_INC: push_entry.value = a + 1'b1;
         fpa_pkg::OP_DEC: push_entry.value = a - 1'b1;
         // arithmetic shift rounds toward minus infinity
         fpa_pkg::OP_INT: push_entry.value = a >>> fpa_pkg::FRAC_BITS;
         default: ;
      endcase
   end

endmodule

/* rtl/core/fpa_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back-end pipeline.
// Depends on fpa_pkg.
module fpa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  fpa_pkg::entry_type    push_entry,
   output logic                  q_full,
   output logic                  pop_valid,
   output fpa_pkg::entry_type    pop_entry,
   input  logic                  pop_ready
);

   fpa_pkg::entry_type mem_ff [0:1];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign q_full    = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !q_full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/core/fpa_back.sv */
`timescale 1ns / 1ps
// Back end: pipelined multiplier with rounding, one-bit-per-stage divider,
// saturation and the response register. Depends on fpa_pkg.
module fpa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  fpa_pkg::entry_type    q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_result_value,
   output logic                  rsp_compare_true,
   output logic                  rsp_overflow,
   output logic                  rsp_divide_by_zero
);

   localparam int W  = fpa_pkg::WORD_WIDTH;
   localparam int F  = fpa_pkg::FRAC_BITS;
   localparam int NW = fpa_pkg::DIV_BITS;
   localparam int RW = fpa_pkg::REM_BITS;
   localparam int P  = fpa_pkg::PROD_BITS;

   logic                   adv;
   logic                   vld_ff  [0:NW];
   fpa_pkg::meta_type      meta_ff [0:NW];
   logic [RW-1:0]          rem_ff  [0:NW];
   logic [NW-1:0]          quo_ff  [0:NW];
   logic [RW-1:0]          den_ff  [0:NW];

   logic signed [W-1:0]    opa_ff, opb_ff;
   logic signed [P-1:0]    prod_ff;
   logic [P-1:0]           pmag_ff;
   logic [P-1:0]           mul_m;
   logic                   mul_ovf;
   logic [W-1:0]           mul_val;

   logic                   rsp_valid_ff;
   logic signed [W-1:0]    value_ff, value_in;
   logic                   cmp_ff, ovf_ff, ovf_in, dz_ff;
   logic [NW-1:0]          div_q;
   fpa_pkg::meta_type      last;

   // whole pipeline moves together; it freezes only when a response is held
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0].kind  <= q_entry.kind;
         meta_ff[0].value <= q_entry.value;
         meta_ff[0].cmp   <= q_entry.cmp;
         meta_ff[0].ovf   <= 1'b0;
         meta_ff[0].dz    <= q_entry.dz;
         meta_ff[0].neg   <= q_entry.neg;
         opa_ff           <= q_entry.a;
         opb_ff           <= q_entry.b;
         rem_ff[0]        <= '0;
         quo_ff[0]        <= (NW'(q_entry.mag_a) << (F + 1)) + NW'(q_entry.mag_b);
         den_ff[0]        <= RW'(q_entry.mag_b) << 1;
      end
   end

   // multiply path runs beside the first divider stages
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= opa_ff * opb_ff;
         pmag_ff <= prod_ff[P-1] ? P'(-prod_ff) : P'(prod_ff);
      end
   end

   always_comb begin
      mul_m = (pmag_ff + (P'(1) << (F - 1))) >> F;
      if (meta_ff[2].neg) begin
         mul_ovf = (|mul_m[P-1:W]) || (mul_m[W-1] && (|mul_m[W-2:0]));
         mul_val = mul_ovf ? {1'b1, {(W-1){1'b0}}} : -mul_m[W-1:0];
      end else begin
         mul_ovf = |mul_m[P-1:W-1];
         mul_val = mul_ovf ? {1'b0, {(W-1){1'b1}}} : mul_m[W-1:0];
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_stage
      logic [RW:0]         t;
      logic                ge;
      fpa_pkg::meta_type   meta_in;

      assign t  = {rem_ff[k-1], quo_ff[k-1][NW-1]};
      assign ge = (t >= {1'b0, den_ff[k-1]});

      // the product joins its request on the way into the fourth stage
      always_comb begin
         meta_in = meta_ff[k-1];
         if (k == 3 && meta_ff[k-1].kind == fpa_pkg::KIND_MUL) begin
            meta_in.value = mul_val;
            meta_in.ovf   = mul_ovf;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? RW'(t - {1'b0, den_ff[k-1]}) : RW'(t);
            quo_ff[k]  <= {quo_ff[k-1][NW-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            meta_ff[k] <= meta_in;
         end
      end
   end

   always_comb begin
      last     = meta_ff[NW];
      div_q    = quo_ff[NW];
      value_in = last.value;
      ovf_in   = last.ovf;
      if (last.kind == fpa_pkg::KIND_DIV) begin
         if (last.dz) begin
            value_in = '0;
            ovf_in   = 1'b0;
         end else if (last.neg) begin
            ovf_in   = (|div_q[NW-1:W]) || (div_q[W-1] && (|div_q[W-2:0]));
            value_in = ovf_in ? {1'b1, {(W-1){1'b0}}} : -div_q[W-1:0];
         end else begin
            ovf_in   = |div_q[NW-1:W-1];
            value_in = ovf_in ? {1'b0, {(W-1){1'b1}}} : div_q[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
         cmp_ff   <= last.cmp;
         ovf_ff   <= ovf_in;
         dz_ff    <= last.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = 32'(value_ff);
   assign rsp_compare_true   = cmp_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

/* rtl/core/fixed_point_alu.sv */
`timescale 1ns / 1ps
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, compare, min/max, inc/dec, integer part.
// A new request is taken every cycle while the queue has room. Every request passes
// through the one-bit-per-stage divider pipeline. Responses come out in order. A stalled
// response freezes the pipeline, and the two-entry request queue keeps taking requests
// until it fills.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
module fixed_point_alu (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_opcode,
   input  logic signed [31:0]  req_operand_a,
   input  logic signed [31:0]  req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_result_value,
   output logic                rsp_compare_true,
   output logic                rsp_overflow,
   output logic                rsp_divide_by_zero
);

   logic                push_valid, q_full, pop_valid, pop_ready;
   fpa_pkg::entry_type  push_entry, pop_entry;

   fpa_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .q_full        (q_full),
      .push_valid    (push_valid),
      .push_entry    (push_entry)
   );

   fpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   fpa_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (pop_valid),
      .q_entry            (pop_entry),
      .q_pop              (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

/* tb/alu_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the fixed-point ALU: predicts each response from the request.
// Depends on fpa_pkg for opcodes and the Q format constants.
class alu_scoreboard;
   typedef struct {
      logic signed [31:0] value;
      logic               cmp;
      logic               ovf;
      logic               dz;
   } alu_result_t;

   alu_result_t pending_results[$];
   int          error_count;

   function new();
      error_count = 0;
   endfunction

   // exact integer model at the block's Q format
   function alu_result_t compute(logic [3:0] op, logic signed [31:0] a_in,
                                 logic signed [31:0] b_in);
      alu_result_t res;
      longint a, b, p, wmax, wmin, s;
      logic [63:0] m, ua, ub;
      a = a_in;
      b = b_in;
      wmax = (64'sd1 <<< (fpa_pkg::WORD_WIDTH - 1)) - 1;
      wmin = -wmax - 1;
      res.value = '0;
      res.cmp = 1'b0;
      res.ovf = 1'b0;
      res.dz = 1'b0;
      s = 0;
      case (op)
         fpa_pkg::OP_ADD: res.value = a_in + b_in;
         fpa_pkg::OP_SUB: res.value = a_in - b_in;
         fpa_pkg::OP_MUL: begin
            p = a * b;
            m = ((p < 0) ? -p : p) + (64'd1 << (fpa_pkg::FRAC_BITS - 1));
            m = m >> fpa_pkg::FRAC_BITS;
            s = (p < 0) ? -longint'(m) : longint'(m);
         end
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               res.dz = 1'b1;
            end else begin
               ua = ((a < 0) ? -a : a) << fpa_pkg::FRAC_BITS;
               ub = (b < 0) ? -b : b;
               m = (2 * ua + ub) / (2 * ub);
               s = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
            end
         end
         fpa_pkg::OP_LT: res.cmp = a < b;
         fpa_pkg::OP_GT: res.cmp = a > b;
         fpa_pkg::OP_LE: res.cmp = a <= b;
         fpa_pkg::OP_GE: res.cmp = a >= b;
         fpa_pkg::OP_EQ: res.cmp = a == b;
         fpa_pkg::OP_NE: res.cmp = a != b;
         fpa_pkg::OP_MIN: res.value = (a < b) ? a_in : b_in;
         fpa_pkg::OP_MAX: res.value = (a > b) ? a_in : b_in;
         fpa_pkg::OP_INC: res.value = a_in + 32'sd1;
         fpa_pkg::OP_DEC: res.value = a_in - 32'sd1;
         fpa_pkg::OP_INT: res.value = a_in >>> fpa_pkg::FRAC_BITS;
         default: ;
      endcase
      if (op == fpa_pkg::OP_MUL || (op == fpa_pkg::OP_DIV && !res.dz)) begin
         if (s > wmax) begin
            s = wmax;
            res.ovf = 1'b1;
         end else if (s < wmin) begin
            s = wmin;
            res.ovf = 1'b1;
         end
         res.value = s[31:0];
      end
      return res;
   endfunction

   function void note_request(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      pending_results.push_back(compute(op, a, b));
   endfunction

   function void check_response(logic signed [31:0] value, logic cmp, logic ovf, logic dz);
      alu_result_t want;
      if (pending_results.size() == 0) begin
         $error("unexpected response value=%0d", value);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
         $error("result_value: expected %0d, got %0d", want.value, value);
         error_count++;
      end
      if (cmp !== want.cmp) begin
         $error("compare_true: expected %0b, got %0b", want.cmp, cmp);
         error_count++;
      end
      if (ovf !== want.ovf) begin
         $error("overflow: expected %0b, got %0b", want.ovf, ovf);
         error_count++;
      end
      if (dz !== want.dz) begin
         $error("divide_by_zero: expected %0b, got %0b", want.dz, dz);
         error_count++;
      end
   endfunction
endclass

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for fixed_point_alu: directed and random requests, random stalls.
// Depends on fpa_pkg, the ALU RTL and alu_scoreboard.
module tb_top;

   localparam int LATENCY = fpa_pkg::DIV_BITS + 2;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_opcode = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic               rsp_overflow;
   logic               rsp_divide_by_zero;

   alu_scoreboard scoreboard = new();
   bit            calm_phase = 1'b0;
   bit            long_hold = 1'b0;
   bit            stimulus_done = 1'b0;

   fixed_point_alu u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests and responses noted at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         scoreboard.note_request(req_opcode, req_operand_a, req_operand_b);
      if (!reset && rsp_valid && !rsp_stall)
         scoreboard.check_response(rsp_result_value, rsp_compare_true, rsp_overflow,
                                   rsp_divide_by_zero);
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 3);
         3: return -$signed(32'($urandom_range(0, 4096)));
         4: return $signed($urandom_range(0, 65535)) - 32768;
         5: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic signed [31:0] edge_vals [6] = '{32'sh7fffffff, 32'sh80000000, 32'sd0,
                                            -32'sd1, 32'sd256, -32'sd384};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // every opcode, including the unused one, over extreme operands
      for (int op = 0; op < 16; op++) begin
         send_request(op[3:0], edge_vals[op % 6], edge_vals[(op + 2) % 6]);
      end
      send_request(fpa_pkg::OP_DIV, 32'sd1000, 32'sd0);
      send_request(fpa_pkg::OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
      send_request(fpa_pkg::OP_MUL, 32'sd384, -32'sd128);        // exact product, no rounding tie
      send_request(fpa_pkg::OP_DIV, 32'sh80000000, -32'sd1);
      send_request(fpa_pkg::OP_MIN, 32'sd77, 32'sd77);
      send_request(fpa_pkg::OP_INT, -32'sd1, 32'sd0);
      send_request(fpa_pkg::OP_EQ, 32'sd5, 32'sd5);
      drain();
      // fill the block while the receiver holds off
      long_hold = 1'b1;
      for (int i = 0; i < 60; i++) send_request(4'($urandom_range(0, 15)), rand_operand(),
                                                rand_operand());
      drain();
      for (int i = 0; i < 900; i++) begin
         if (i == 750) calm_phase = 1'b1;
         if (i == 400) drain();
         send_request(($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                      : 4'($urandom_range(0, 14)), rand_operand(), rand_operand());
         idle_gap();
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule
